@@ rtl/mpc_pkg.sv @@
// Package for the memory pattern checker: pattern constants, field widths,
// and the command/status types shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package mpc_pkg;

    localparam int INDEX_BITS = 32;

    localparam logic [63:0] INDEX_MASK = (INDEX_BITS >= 64) ? {64{1'b1}} :
                                         ((64'd1 << INDEX_BITS) - 64'd1);

    localparam logic [63:0] SM_GAMMA  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2   = 64'h94D049BB133111EB;
    localparam logic [63:0] PAT_CONST = 64'h4246C99787241DC5;
    localparam logic [63:0] PAT_ZEROS = 64'h0000000000000000;
    localparam logic [63:0] PAT_ONES  = 64'hFFFFFFFFFFFFFFFF;
    localparam logic [63:0] PAT_SEED  = 64'h54C5C3A55AA55AA5;
    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;
    localparam logic [31:0] REPORT_LIMIT_RESET = 32'd32;

    localparam int S_TDATA_BITS = 104;
    localparam int S_TUSER_BITS = 3;
    localparam int M_TDATA_BITS = 264;

    // pattern pass codes
    localparam logic [1:0] PASS_CONST = 2'd0;
    localparam logic [1:0] PASS_ZEROS = 2'd1;
    localparam logic [1:0] PASS_ONES  = 2'd2;
    localparam logic [1:0] PASS_HASH  = 2'd3;

    // partial product selected for the 64-bit modular multiply
    typedef enum logic [1:0] {
        MUL_LO_LO = 2'd0,
        MUL_HI_LO = 2'd1,
        MUL_LO_HI = 2'd2
    } mul_phase_t;

    typedef struct packed {
        logic       load;       // latch the accepted word
        logic       prep;       // operand from index, seed and gamma
        logic       shift;      // operand from accumulator, xor-shift 27
        logic       mul_en;     // one partial product into the accumulator
        mul_phase_t mul_phase;
        logic       const_sel;  // 0: first multiplier constant, 1: second
        logic       commit;     // update counts and load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic is_hash;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/memory_pattern_checker_unit.sv @@
// Memory pattern checker: pattern generation, compare, mismatch counts and
// checksum, one result word per input word.
// Depends on mpc_pkg, mpc_ctrl and mpc_datapath.
//
// Usage:
//   s_ channel takes one command word per handshake; m_ channel returns one
//   result word for each. The cfg channel writes report_limit; it is always
//   ready and should only be written while no word is in flight.
//   Sequence: constant, zeros and ones passes go from acceptance through the
//   prep and finish states; the hashed pass runs two 64-bit multiplies in
//   between, each as three partial products on one 32x32 multiplier.
//   A new word is not accepted until the last one commits its result, as
//   s_tready is high only while the controller is idle.
//   A finished result sits in the output register; the next word may be
//   accepted meanwhile, but its result waits until m_tready takes the first.
//   Reset clears the counts and checksum, sets report_limit to 32 and drops
//   m_tvalid.
`default_nettype none

module memory_pattern_checker_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // word_index [31:0], observed_word [95:32], first_of_pass [96], zero pad
    input  wire logic [mpc_pkg::S_TDATA_BITS-1:0] s_tdata,
    // command [0], pass_number [2:1]
    input  wire logic [mpc_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // expected_word [63:0], mismatch [64], difference_bits [128:65],
    // report [129], pass_mismatch_count [161:130],
    // total_mismatch_count [193:162], running_checksum [257:194],
    // all_passed [258], zero pad
    output logic [mpc_pkg::M_TDATA_BITS-1:0]      m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [31:0]                      cfg_data
);

    mpc_pkg::dp_cmd_t    cmd;
    mpc_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mpc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/mpc_datapath.sv @@
// Datapath of the memory pattern checker: input latch, splitmix multiplier
// built on one 32x32 multiplier, counters, checksum and result register.
// Depends on mpc_pkg.
`default_nettype none

module mpc_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire mpc_pkg::dp_cmd_t                 cmd,
    output mpc_pkg::dp_status_t                   status,
    input  wire logic [mpc_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  wire logic [mpc_pkg::S_TUSER_BITS-1:0] s_tuser,
    input  wire logic                             cfg_write,
    input  wire logic [31:0]                      cfg_data,
    output logic [mpc_pkg::M_TDATA_BITS-1:0]      m_tdata
);

    logic        check_reg;
    logic [1:0]  pass_reg;
    logic [63:0] idx_reg;
    logic [63:0] obs_reg;
    logic        first_reg;
    logic [63:0] op_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] limit_reg;
    logic [63:0] checksum_reg;
    logic [63:0] checksum_next;
    logic [31:0] pass_cnt_reg;
    logic [31:0] pass_cnt_next;
    logic [31:0] total_cnt_reg;
    logic [31:0] total_cnt_next;
    logic [mpc_pkg::M_TDATA_BITS-1:0] out_reg;
    logic [mpc_pkg::M_TDATA_BITS-1:0] out_next;

    logic [63:0] prep_sum;
    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;
    logic [63:0] hash_word;
    logic [63:0] expected;
    logic [63:0] diff;
    logic        miss;
    logic        rep;
    logic [31:0] pass_base;

    assign status.is_hash = (pass_reg == mpc_pkg::PASS_HASH);
    assign m_tdata = out_reg;

    assign prep_sum  = (idx_reg ^ mpc_pkg::PAT_SEED) + mpc_pkg::SM_GAMMA;
    assign mul_const = cmd.const_sel ? mpc_pkg::SM_MUL2 : mpc_pkg::SM_MUL1;

    always_comb begin
        unique case (cmd.mul_phase)
            mpc_pkg::MUL_LO_LO: begin
                mul_a = op_reg[31:0];
                mul_b = mul_const[31:0];
            end
            mpc_pkg::MUL_HI_LO: begin
                mul_a = op_reg[63:32];
                mul_b = mul_const[31:0];
            end
            mpc_pkg::MUL_LO_HI: begin
                mul_a = op_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default: begin
                mul_a = op_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

    // cross products only reach the upper half of the 64-bit result
    assign acc_next = (cmd.mul_phase == mpc_pkg::MUL_LO_LO) ? mul_prod :
                      acc_reg + {mul_prod[31:0], 32'd0};

    assign hash_word = acc_reg ^ (acc_reg >> 31);

    always_comb begin
        unique case (pass_reg)
            mpc_pkg::PASS_CONST: expected = mpc_pkg::PAT_CONST;
            mpc_pkg::PASS_ZEROS: expected = mpc_pkg::PAT_ZEROS;
            mpc_pkg::PASS_ONES:  expected = mpc_pkg::PAT_ONES;
            default:             expected = hash_word;
        endcase
    end

    assign diff      = check_reg ? (expected ^ obs_reg) : 64'd0;
    assign miss      = |diff;
    assign rep       = miss && (total_cnt_reg < limit_reg);
    assign pass_base = first_reg ? 32'd0 : pass_cnt_reg;

    always_comb begin
        pass_cnt_next  = pass_base;
        total_cnt_next = total_cnt_reg;
        checksum_next  = checksum_reg;
        if (check_reg) begin
            checksum_next = checksum_reg ^ (obs_reg + idx_reg);
        end
        if (miss) begin
            if (pass_base != mpc_pkg::COUNT_MAX) begin
                pass_cnt_next = pass_base + 32'd1;
            end
            if (total_cnt_reg != mpc_pkg::COUNT_MAX) begin
                total_cnt_next = total_cnt_reg + 32'd1;
            end
        end
        out_next = {5'd0,
                    (total_cnt_next == 32'd0),
                    checksum_next,
                    total_cnt_next,
                    pass_cnt_next,
                    rep,
                    diff,
                    miss,
                    expected};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= mpc_pkg::REPORT_LIMIT_RESET;
            checksum_reg  <= 64'd0;
            pass_cnt_reg  <= 32'd0;
            total_cnt_reg <= 32'd0;
        end else begin
            if (cfg_write) begin
                limit_reg <= cfg_data;
            end
            if (cmd.commit) begin
                checksum_reg  <= checksum_next;
                pass_cnt_reg  <= pass_cnt_next;
                total_cnt_reg <= total_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            check_reg <= s_tuser[0];
            pass_reg  <= s_tuser[2:1];
            idx_reg   <= {32'd0, s_tdata[31:0]} & mpc_pkg::INDEX_MASK;
            obs_reg   <= s_tdata[95:32];
            first_reg <= s_tdata[96];
        end
        if (cmd.prep) begin
            op_reg <= prep_sum ^ (prep_sum >> 30);
        end else if (cmd.shift) begin
            op_reg <= acc_reg ^ (acc_reg >> 27);
        end
        if (cmd.mul_en) begin
            acc_reg <= acc_next;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mpc_ctrl.sv @@
// Controller of the memory pattern checker: sequences the hash multiplies,
// owns the input ready and the result valid flag.
// Depends on mpc_pkg.
`default_nettype none

module mpc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire mpc_pkg::dp_status_t status,
    output mpc_pkg::dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_M1A,
        ST_M1B,
        ST_M1C,
        ST_SHIFT,
        ST_M2A,
        ST_M2B,
        ST_M2C,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        cmd = '0;
        cmd.mul_phase = mpc_pkg::MUL_LO_LO;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                state_next = status.is_hash ? ST_M1A : ST_FINISH;
            end
            ST_M1A: begin
                cmd.mul_en = 1'b1;
                state_next = ST_M1B;
            end
            ST_M1B: begin
                cmd.mul_en = 1'b1;
                cmd.mul_phase = mpc_pkg::MUL_HI_LO;
                state_next = ST_M1C;
            end
            ST_M1C: begin
                cmd.mul_en = 1'b1;
                cmd.mul_phase = mpc_pkg::MUL_LO_HI;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                state_next = ST_M2A;
            end
            ST_M2A: begin
                cmd.mul_en = 1'b1;
                cmd.const_sel = 1'b1;
                state_next = ST_M2B;
            end
            ST_M2B: begin
                cmd.mul_en = 1'b1;
                cmd.const_sel = 1'b1;
                cmd.mul_phase = mpc_pkg::MUL_HI_LO;
                state_next = ST_M2C;
            end
            ST_M2C: begin
                cmd.mul_en = 1'b1;
                cmd.const_sel = 1'b1;
                cmd.mul_phase = mpc_pkg::MUL_LO_HI;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the result register is free
                cmd.commit = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ dv/memory_pattern_checker_unit_tb.sv @@
// Testbench for memory_pattern_checker_unit: drives pattern write and check
// words, predicts every result word and compares it field by field.
// Depends on mpc_pkg and the memory_pattern_checker_unit RTL.
`timescale 1ns / 100ps

module memory_pattern_checker_unit_tb;

    localparam bit CMD_WRITE = 1'b0;
    localparam bit CMD_CHECK = 1'b1;

    localparam bit [63:0] GOLDEN     = 64'h9E3779B97F4A7C15;
    localparam bit [63:0] MIX_A      = 64'hBF58476D1CE4E5B9;
    localparam bit [63:0] MIX_B      = 64'h94D049BB133111EB;
    localparam bit [63:0] FIXED_WORD = 64'h4246C99787241DC5;
    localparam bit [63:0] HASH_SEED  = 64'h54C5C3A55AA55AA5;
    localparam bit [31:0] COUNT_TOP  = 32'hFFFFFFFF;
    localparam bit [63:0] IDX_KEEP   = (mpc_pkg::INDEX_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << mpc_pkg::INDEX_BITS) - 64'd1);
    localparam int STALL_LIMIT       = 2000;
    localparam int RANDOM_WORDS      = 1950;

    typedef struct {
        bit        cmd;
        bit [1:0]  pass_no;
        bit [31:0] index;
        bit [63:0] observed;
        bit        first;
    } probe_t;

    typedef struct {
        bit [63:0] pattern;
        bit        miss;
        bit [63:0] diff;
        bit        report;
        bit [31:0] pass_cnt;
        bit [31:0] total_cnt;
        bit [63:0] checksum;
        bit        clean;
    } verdict_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [mpc_pkg::S_TDATA_BITS-1:0] s_tdata;
    logic [mpc_pkg::S_TUSER_BITS-1:0] s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [mpc_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [31:0]                      cfg_data;

    // predictor state
    bit [63:0] checksum_acc;
    bit [31:0] pass_errors;
    bit [31:0] total_errors;
    bit [31:0] report_limit;

    verdict_t awaited_verdicts[$];

    bit steady_flow;
    int error_count;
    int words_sent;
    int checks_sent;
    int misses_predicted;
    int reports_predicted;
    int limit_writes;
    int idle_cycles;

    memory_pattern_checker_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit [63:0] splitmix(input bit [63:0] seed_val);
        bit [63:0] z;
        z = seed_val + GOLDEN;
        z = (z ^ (z >> 30)) * MIX_A;
        z = (z ^ (z >> 27)) * MIX_B;
        return z ^ (z >> 31);
    endfunction

    function automatic bit [63:0] pattern_of(input bit [1:0] pass_no, input bit [31:0] index);
        case (pass_no)
            mpc_pkg::PASS_CONST: return FIXED_WORD;
            mpc_pkg::PASS_ZEROS: return 64'd0;
            mpc_pkg::PASS_ONES:  return {64{1'b1}};
            default:    return splitmix(({32'd0, index} & IDX_KEEP) ^ HASH_SEED);
        endcase
    endfunction

    function automatic bit [31:0] bump(input bit [31:0] count);
        return (count == COUNT_TOP) ? count : count + 32'd1;
    endfunction

    function automatic probe_t make_probe(input bit cmd, input bit [1:0] pass_no,
                                          input bit [31:0] index, input bit [63:0] observed,
                                          input bit first);
        probe_t p;
        p.cmd = cmd;
        p.pass_no = pass_no;
        p.index = index;
        p.observed = observed;
        p.first = first;
        return p;
    endfunction

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // single bit, scattered bits or every bit
    function automatic bit [63:0] fault_mask();
        bit [63:0] m;
        case ($urandom_range(0, 3))
            0, 1:    m = 64'd1 << $urandom_range(0, 63);
            2:       m = rand64();
            default: m = {64{1'b1}};
        endcase
        return (m == 64'd0) ? 64'd1 : m;
    endfunction

    // advance the predictor by one accepted word and queue its result
    task automatic apply_probe(input probe_t p);
        verdict_t v;
        bit [63:0] idx;
        idx = {32'd0, p.index} & IDX_KEEP;
        v.pattern = pattern_of(p.pass_no, p.index);
        v.miss = 1'b0;
        v.diff = 64'd0;
        v.report = 1'b0;
        if (p.first)
            pass_errors = 32'd0;
        if (p.cmd == CMD_CHECK) begin
            checks_sent++;
            checksum_acc ^= p.observed + idx;
            v.diff = v.pattern ^ p.observed;
            v.miss = (v.diff != 64'd0);
            if (v.miss) begin
                v.report = (total_errors < report_limit);
                pass_errors = bump(pass_errors);
                total_errors = bump(total_errors);
                misses_predicted++;
                if (v.report)
                    reports_predicted++;
            end
        end
        v.pass_cnt = pass_errors;
        v.total_cnt = total_errors;
        v.checksum = checksum_acc;
        v.clean = (total_errors == 32'd0);
        awaited_verdicts.push_back(v);
    endtask

    // present one word from a falling edge and hold it until taken
    task automatic send_word(input probe_t p);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, p.first, p.observed, p.index};
        s_tuser <= {p.pass_no, p.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_probe(p);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_report_limit(input bit [31:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        report_limit = value;
        limit_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input bit [63:0] want, input bit [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    // result side: random stalls, compare every word taken
    initial begin
        verdict_t v;
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap();
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (awaited_verdicts.size() == 0) begin
                $error("result word with no word outstanding: %h", m_tdata);
                error_count++;
            end else begin
                v = awaited_verdicts.pop_front();
                check_field("expected_word", v.pattern, m_tdata[63:0]);
                check_field("mismatch", v.miss, m_tdata[64]);
                check_field("difference_bits", v.diff, m_tdata[128:65]);
                check_field("report", v.report, m_tdata[129]);
                check_field("pass_mismatch_count", v.pass_cnt, m_tdata[161:130]);
                check_field("total_mismatch_count", v.total_cnt, m_tdata[193:162]);
                check_field("running_checksum", v.checksum, m_tdata[257:194]);
                check_field("all_passed", v.clean, m_tdata[258]);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed_patterns();
        bit [63:0] h;
        steady_flow = 1'b0;
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_CONST, 32'd0, 64'd0, 1'b1));
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_ZEROS, 32'hFFFFFFFF, {64{1'b1}},
                             1'b0));
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_ONES, 32'h5A5A5A5A, 64'd0, 1'b0));
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_HASH, 32'd0, 64'd0, 1'b0));
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_HASH, 32'hFFFFFFFF, rand64(), 1'b0));
        // matching reads on every pass
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_CONST, 32'd0, FIXED_WORD, 1'b0));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_ZEROS, 32'hFFFFFFFF, 64'd0, 1'b0));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_ONES, 32'd1, {64{1'b1}}, 1'b0));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_HASH, 32'd0,
                             pattern_of(mpc_pkg::PASS_HASH, 32'd0), 1'b0));
        // top bit flipped on the hashed pass, then whole-word faults
        h = pattern_of(mpc_pkg::PASS_HASH, 32'hFFFFFFFF) ^ 64'h8000000000000000;
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_HASH, 32'hFFFFFFFF, h, 1'b0));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_CONST, 32'h80000000, 64'd0, 1'b0));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_ZEROS, 32'd7, {64{1'b1}}, 1'b0));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_ONES, 32'd9, 64'd0, 1'b0));
        // observed plus index wraps past 2^64
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_ONES, 32'hFFFFFFFF, {64{1'b1}},
                             1'b0));
        // a write still clears the pass count, the total stays
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_ZEROS, 32'd3, 64'd0, 1'b1));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_ZEROS, 32'd4, 64'd1, 1'b1));
        send_word(make_probe(CMD_CHECK, mpc_pkg::PASS_HASH, 32'h12345678, rand64(), 1'b0));
        send_word(make_probe(CMD_WRITE, mpc_pkg::PASS_CONST, 32'hA5A5A5A5, rand64(), 1'b0));
    endtask

    task automatic test_report_limit();
        bit [31:0] edge_limits[3];
        edge_limits[0] = 32'd0;
        edge_limits[1] = 32'hFFFFFFFF;
        edge_limits[2] = 32'd0;
        foreach (edge_limits[k]) begin
            // last setting sits just above the running total to catch the boundary
            if (k == 2)
                edge_limits[k] = total_errors + 32'd2;
            write_report_limit(edge_limits[k]);
            steady_flow = (k == 1);
            repeat (5)
                send_word(make_probe(CMD_CHECK, 2'($urandom_range(0, 3)), $urandom,
                                     {64{1'b1}} ^ FIXED_WORD ^ fault_mask(), 1'b0));
        end
    endtask

    // pass-structured memory test: write a block, read it back with rare faults
    task automatic run_block();
        bit [1:0]  pass_no;
        bit [31:0] base;
        bit [63:0] obs;
        int        len;
        pass_no = 2'($urandom_range(0, 3));
        base = ($urandom_range(0, 7) == 0) ? 32'hFFFFFFF0 : $urandom;
        len = $urandom_range(1, 24);
        steady_flow = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_word(make_probe(CMD_WRITE, pass_no, base + i, rand64(), i == 0));
        for (int i = 0; i < len; i++) begin
            obs = pattern_of(pass_no, base + i);
            if ($urandom_range(0, 5) == 0)
                obs ^= fault_mask();
            send_word(make_probe(CMD_CHECK, pass_no, base + i, obs, $urandom_range(0, 31) == 0));
        end
    endtask

    task automatic test_random_traffic();
        int phase_end;
        int target;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            case ($urandom_range(0, 4))
                0:       write_report_limit(32'd0);
                1:       write_report_limit(32'hFFFFFFFF);
                2:       write_report_limit($urandom);
                default: write_report_limit(total_errors + $urandom_range(0, 40));
            endcase
            phase_end = words_sent + $urandom_range(150, 350);
            while (words_sent < phase_end && words_sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    steady_flow = 1'b0;
                    repeat ($urandom_range(1, 6))
                        send_word(make_probe(1'($urandom), 2'($urandom), $urandom, rand64(),
                                             1'($urandom_range(0, 3) == 0)));
                end else begin
                    run_block();
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        checksum_acc = 64'd0;
        pass_errors = 32'd0;
        total_errors = 32'd0;
        report_limit = 32'd32;
        steady_flow = 1'b0;
        idle_cycles = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_patterns();
        test_report_limit();
        test_random_traffic();

        drain();
        repeat (20) @(posedge aclk);
        $display("%0d words (%0d checks), %0d mismatches, %0d reported, %0d limit writes",
                 words_sent, checks_sent, misses_predicted, reports_predicted, limit_writes);
        $display("final checksum %h, total mismatch count %0d", checksum_acc, total_errors);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
